// ----- hw/rtl/ogg_page_framer_defines.svh -----
// assertion helpers for the page framer
`ifndef OGG_PAGE_FRAMER_DEFINES_SVH
`define OGG_PAGE_FRAMER_DEFINES_SVH

// assert a property on the rising clock, disabled in reset
`define OPF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// assert an implication whose consequent is checked in the next cycle
`define OPF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/opf_pkg.sv -----
package opf_pkg;

	localparam int unsigned PAYLOAD_BYTES_DEF = 8192;
	localparam int unsigned MAX_SEGMENTS_DEF  = 64;
	localparam int unsigned HDR_LEN           = 27;
	localparam logic [31:0] CRC_POLY          = 32'h04c11db7;
	localparam logic [31:0] SERIAL_RESET      = 32'h4f505553;

	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_END    = 2'd1,
		ACT_CLOSE  = 2'd2,
		ACT_READ   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_LONG = 2'd1,
		ST_ROOM = 2'd2,
		ST_BUSY = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		FS_IDLE,
		FS_RESP,
		FS_CRC_ADDR,
		FS_CRC_DATA,
		FS_READ_WAIT,
		FS_READ_DATA
	} fsm_t;

	// one byte through the crc, eight dependent narrow steps
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {b, 24'd0};
		for (int k = 0; k < 8; k++) begin
			c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// ----- hw/rtl/opf_ram.sv -----
module opf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/ogg_page_framer.sv -----
// ogg page framer: one word in flight, the next taken the cycle after its result leaves
// append, end packet, busy words, read before ready, dropped close: result registered in FS_RESP
// close: bound by the crc walk over the header, lacing and payload bytes
//   that reads each page byte in FS_CRC_ADDR then FS_CRC_DATA through the store read ports
// read of a page byte: FS_RESP, FS_READ_WAIT, FS_READ_DATA, one registered store read
// arst_n clears all control state; the stores are left undefined
module ogg_page_framer
	import opf_pkg::*;
#(
	parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
	parameter int unsigned MAX_SEGMENTS  = MAX_SEGMENTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration word
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	// input words
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  data_byte,
	input  logic [63:0] granule,
	input  logic [31:0] page_seq,
	input  logic        first_page,
	input  logic        last_page,
	// result words
	output logic        out_valid_word,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [7:0]  out_byte,
	output logic        out_valid,
	output logic        page_end
);

	localparam int unsigned PW = $clog2(PAYLOAD_BYTES);
	localparam int unsigned SW = $clog2(MAX_SEGMENTS);
	// fill counts hold the depth itself
	localparam int unsigned FW = $clog2(PAYLOAD_BYTES + 1);
	localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
	// page total and positions may run past payload size
	localparam int unsigned TW = $clog2(PAYLOAD_BYTES + MAX_SEGMENTS + HDR_LEN + 2);

	// state
	fsm_t              state_q, state_d;
	logic [31:0]       serial_q, lserial_q;
	logic [FW-1:0]     fill_q;
	logic [7:0]        plen_q;
	logic [CW-1:0]     segs_q;
	logic [63:0]       gran_q;
	logic [31:0]       seq_q;
	logic [7:0]        flags_q;
	logic [31:0]       crc_q;
	logic [TW-1:0]     pos_q;
	logic              ready_q;
	logic [1:0]        err_q;

	// result register
	logic              ov_q;
	logic [1:0]        st_q;
	logic [7:0]        ob_q;
	logic              obv_q;
	logic              pe_q;

	// captured input word
	logic [1:0]        act_q;

	// memory ports
	logic              pay_we, lac_we;
	logic [PW-1:0]     pay_waddr, pay_raddr;
	logic [SW-1:0]     lac_waddr, lac_raddr;
	logic [7:0]        pay_wdata, lac_wdata, pay_rdata, lac_rdata;

	logic              accept;
	logic              close_big;
	logic [TW-1:0]     total;
	logic [TW-1:0]     rel_l, rel_p;
	logic [7:0]        hdr_byte, page_b;
	logic [1:0]        sel_q;   // 0 header, 1 lacing, 2 payload, 3 zero
	logic [7:0]        hdr_q;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != FS_IDLE) || ov_q;
	assign cfg_ready = 1'b1;

	assign out_valid_word = ov_q;
	assign status         = st_q;
	assign out_byte       = ob_q;
	assign out_valid      = obv_q;
	assign page_end       = pe_q;

	assign total = TW'(HDR_LEN) + TW'(segs_q) + TW'(fill_q);
	assign rel_l = pos_q - TW'(HDR_LEN);
	assign rel_p = rel_l - TW'(segs_q);

	// page too big once the unfinished packet is dropped
	assign close_big = (TW'(HDR_LEN) + TW'(segs_q) + TW'(fill_q - FW'(plen_q)))
		> TW'(PAYLOAD_BYTES);

	// header byte at the current position, crc field included when wanted
	always_comb begin
		hdr_byte = 8'd0;
		case (pos_q[4:0])
			5'd0:  hdr_byte = 8'h4f;
			5'd1:  hdr_byte = 8'h67;
			5'd2:  hdr_byte = 8'h67;
			5'd3:  hdr_byte = 8'h53;
			5'd5:  hdr_byte = flags_q;
			5'd6:  hdr_byte = gran_q[7:0];
			5'd7:  hdr_byte = gran_q[15:8];
			5'd8:  hdr_byte = gran_q[23:16];
			5'd9:  hdr_byte = gran_q[31:24];
			5'd10: hdr_byte = gran_q[39:32];
			5'd11: hdr_byte = gran_q[47:40];
			5'd12: hdr_byte = gran_q[55:48];
			5'd13: hdr_byte = gran_q[63:56];
			5'd14: hdr_byte = lserial_q[7:0];
			5'd15: hdr_byte = lserial_q[15:8];
			5'd16: hdr_byte = lserial_q[23:16];
			5'd17: hdr_byte = lserial_q[31:24];
			5'd18: hdr_byte = seq_q[7:0];
			5'd19: hdr_byte = seq_q[15:8];
			5'd20: hdr_byte = seq_q[23:16];
			5'd21: hdr_byte = seq_q[31:24];
			5'd22: hdr_byte = (state_q == FS_READ_WAIT) ? crc_q[7:0] : 8'd0;
			5'd23: hdr_byte = (state_q == FS_READ_WAIT) ? crc_q[15:8] : 8'd0;
			5'd24: hdr_byte = (state_q == FS_READ_WAIT) ? crc_q[23:16] : 8'd0;
			5'd25: hdr_byte = (state_q == FS_READ_WAIT) ? crc_q[31:24] : 8'd0;
			5'd26: hdr_byte = 8'(segs_q);
			default: hdr_byte = 8'd0;
		endcase
	end

	// read addresses always follow the current position
	assign pay_raddr = rel_p[PW-1:0];
	assign lac_raddr = rel_l[SW-1:0];

	// byte chosen from the registered reads, in the cycle after the address
	always_comb begin
		case (sel_q)
			2'd0:    page_b = hdr_q;
			2'd1:    page_b = lac_rdata;
			2'd2:    page_b = pay_rdata;
			default: page_b = 8'd0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FS_IDLE: begin
				if (accept) begin
					state_d = FS_RESP;
				end
			end
			FS_RESP: begin
				state_d = FS_IDLE;
				if (act_q == ACT_CLOSE && !ready_q && err_q == ST_OK && !close_big) begin
					state_d = FS_CRC_ADDR;
				end else if (act_q == ACT_READ && ready_q) begin
					state_d = FS_READ_WAIT;
				end
			end
			FS_CRC_ADDR: state_d = FS_CRC_DATA;
			FS_CRC_DATA: state_d = (pos_q >= total) ? FS_IDLE : FS_CRC_ADDR;
			FS_READ_WAIT: state_d = FS_READ_DATA;
			FS_READ_DATA: state_d = FS_IDLE;
			default: state_d = FS_IDLE;
		endcase
	end

	// store writes
	always_comb begin
		pay_we    = 1'b0;
		lac_we    = 1'b0;
		pay_waddr = fill_q[PW-1:0];
		pay_wdata = data_byte;
		lac_waddr = segs_q[SW-1:0];
		lac_wdata = plen_q;
		if (accept && !ready_q) begin
			pay_we = (action == ACT_APPEND) && (plen_q < 8'd254)
				&& (fill_q < FW'(PAYLOAD_BYTES));
			lac_we = (action == ACT_END) && (segs_q < CW'(MAX_SEGMENTS));
		end
	end

	opf_ram #(.WIDTH(8), .DEPTH(PAYLOAD_BYTES)) u_payload (
		.clk(clk), .we(pay_we), .waddr(pay_waddr), .wdata(pay_wdata),
		.raddr(pay_raddr), .rdata(pay_rdata)
	);

	opf_ram #(.WIDTH(8), .DEPTH(MAX_SEGMENTS)) u_lacing (
		.clk(clk), .we(lac_we), .waddr(lac_waddr), .wdata(lac_wdata),
		.raddr(lac_raddr), .rdata(lac_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
			serial_q <= SERIAL_RESET;
			lserial_q <= '0;
			fill_q <= '0;
			plen_q <= '0;
			segs_q <= '0;
			gran_q <= '0;
			seq_q <= '0;
			flags_q <= '0;
			crc_q <= '0;
			pos_q <= '0;
			ready_q <= 1'b0;
			err_q <= ST_OK;
			ov_q <= 1'b0;
			st_q <= ST_OK;
			ob_q <= '0;
			obv_q <= 1'b0;
			pe_q <= 1'b0;
			act_q <= ACT_APPEND;
			sel_q <= 2'd3;
			hdr_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				serial_q <= cfg_data;
			end
			if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
			// registered byte select to line up with the registered store read
			hdr_q <= hdr_byte;
			if (pos_q < TW'(HDR_LEN)) begin
				sel_q <= 2'd0;
			end else if (rel_l < TW'(segs_q)) begin
				sel_q <= 2'd1;
			end else if (rel_p < TW'(fill_q)) begin
				sel_q <= 2'd2;
			end else begin
				sel_q <= 2'd3;
			end

			unique case (state_q)
				FS_IDLE: begin
					if (accept) begin
						act_q <= action;
						ob_q <= 8'd0;
						obv_q <= 1'b0;
						pe_q <= 1'b0;
						if (action == ACT_READ) begin
							st_q <= ready_q ? ST_OK : ST_BUSY;
						end else if (ready_q) begin
							st_q <= ST_BUSY;
						end else begin
							st_q <= ST_OK;
							if (action == ACT_APPEND) begin
								if (plen_q >= 8'd254) begin
									err_q <= ST_LONG;
								end else if (fill_q >= FW'(PAYLOAD_BYTES)) begin
									if (err_q == ST_OK) err_q <= ST_ROOM;
								end else begin
									fill_q <= fill_q + 1'b1;
									plen_q <= plen_q + 1'b1;
								end
							end else if (action == ACT_END) begin
								if (segs_q >= CW'(MAX_SEGMENTS)) begin
									if (err_q == ST_OK) err_q <= ST_ROOM;
									fill_q <= fill_q - FW'(plen_q);
								end else begin
									segs_q <= segs_q + 1'b1;
								end
								plen_q <= '0;
							end else begin
								gran_q <= granule;
								seq_q <= page_seq;
								flags_q <= {5'd0, last_page, first_page, 1'b0};
							end
						end
					end
				end
				FS_RESP: begin
					if (act_q == ACT_APPEND || act_q == ACT_END) begin
						ov_q <= 1'b1;
						if (!ready_q) st_q <= err_q;
					end else if (act_q == ACT_CLOSE && !ready_q) begin
						plen_q <= '0;
						pos_q <= '0;
						if (err_q != ST_OK || close_big) begin
							// page dropped, error reported and cleared
							ov_q <= 1'b1;
							st_q <= (err_q != ST_OK) ? err_q : ST_ROOM;
							err_q <= ST_OK;
							fill_q <= '0;
							segs_q <= '0;
						end else begin
							fill_q <= fill_q - FW'(plen_q);
							lserial_q <= serial_q;
							crc_q <= '0;
						end
					end else if (!(act_q == ACT_READ && ready_q)) begin
						ov_q <= 1'b1;
					end
				end
				FS_CRC_ADDR: begin
					// read issued for pos_q, selection registered
				end
				FS_CRC_DATA: begin
					if (pos_q < total) begin
						crc_q <= crc_byte(crc_q, page_b);
						pos_q <= pos_q + 1'b1;
					end else begin
						pos_q <= '0;
						ready_q <= 1'b1;
						ov_q <= 1'b1;
					end
				end
				FS_READ_WAIT: begin
				end
				FS_READ_DATA: begin
					ob_q <= page_b;
					obv_q <= 1'b1;
					ov_q <= 1'b1;
					if (pos_q + 1'b1 >= total) begin
						pe_q <= 1'b1;
						fill_q <= '0;
						plen_q <= '0;
						segs_q <= '0;
						pos_q <= '0;
						ready_q <= 1'b0;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ----- hw/rtl/opf_checker.sv -----
`include "ogg_page_framer_defines.svh"

module opf_checker
	import opf_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid_word,
	input logic       out_stall,
	input logic [1:0] status,
	input logic       out_valid,
	input logic       page_end
);

	// a stalled result holds
	`OPF_ASSERT_NEXT(a_hold_v, out_valid_word && out_stall, out_valid_word, "word dropped")
	`OPF_ASSERT_NEXT(a_hold, out_valid_word && out_stall, $stable(status), "word moved")

	// page bytes only come with status ok
	`OPF_ASSERT(a_byte_ok, !(out_valid_word && out_valid && status != ST_OK), "byte with error")

	// page end only marks a carried byte
	`OPF_ASSERT(a_end_byte, !(out_valid_word && page_end && !out_valid), "end without byte")

	// no new word taken while a result waits
	`OPF_ASSERT(a_no_overlap, !(out_valid_word && !in_stall), "input open while result waits")

endmodule

bind ogg_page_framer opf_checker u_opf_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid_word(out_valid_word), .out_stall(out_stall), .status(status),
	.out_valid(out_valid), .page_end(page_end)
);
